>>> hdl/big_endian_two_region_memory_core_macros.svh
// ----------------------------------------------------------------------------
// big_endian_two_region_memory_core_macros
// Assertion macros for the two-region memory core.
// ----------------------------------------------------------------------------
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef BIG_ENDIAN_TWO_REGION_MEMORY_CORE_MACROS_SVH
`define BIG_ENDIAN_TWO_REGION_MEMORY_CORE_MACROS_SVH

// Condition holds at every edge outside reset.
`define BETRM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BETRM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BETRM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/betrm_pkg.sv
// ----------------------------------------------------------------------------
// betrm_pkg
// Shared codes, widths and control types of the two-region memory core.
// ----------------------------------------------------------------------------
`default_nettype none

package betrm_pkg;

	localparam int ACTION_W   = 2;
	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 2;
	localparam int DATA_W     = 64;
	localparam int CFG_SIZE_W = 17;
	localparam int CFG_IDX_W  = 1;
	localparam int BYTE_W     = 8;
	localparam int BYTES      = 8;
	localparam int LANE_W     = 3;
	localparam int LEN_W      = 4;

	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_REGION_ONE_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_TWO_SIZE = 1'b1;

	localparam logic [CFG_SIZE_W-1:0] CFG_SIZE_RESET = 17'd65536;

	// Mirrored-address handling: high bit set folds onto the low 30 bits.
	localparam int            MIRROR_BIT = 31;
	localparam logic [ADDR_W-1:0] PHYS_MASK = 32'h3FFF_FFFF;

	typedef struct packed {
		logic load;    // capture an accepted item
		logic exec;    // access the banks with the held item
		logic clr_en;  // zero one row of every bank
		logic finish;  // load the result register
	} betrm_cmd_t;

	typedef struct packed {
		logic is_clear;  // held item is a clear
		logic out_free;  // result register can take a result this cycle
	} betrm_stat_t;

endpackage

`default_nettype wire

>>> hdl/betrm_ram.sv
// ----------------------------------------------------------------------------
// betrm_ram
// Single-port RAM with one write or read per cycle and registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module betrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/betrm_region.sv
// ----------------------------------------------------------------------------
// betrm_region
// One byte store as eight byte-wide banks; unaligned big-endian access of up
// to eight bytes, touching each bank at most once.
// ----------------------------------------------------------------------------
`default_nettype none

module betrm_region import betrm_pkg::*; #(
	parameter int CAPACITY = 65536
) (
	input  wire logic                        clk,
	input  wire logic [$clog2(CAPACITY)-1:0] off,
	input  wire logic [LANE_W-1:0]           len_m1,
	input  wire logic                        wr_en,
	input  wire logic                        rd_en,
	input  wire logic [DATA_W-1:0]           wdata,
	input  wire logic                        clr_en,
	input  wire logic [$clog2(CAPACITY)-4:0] clr_row,
	output logic      [DATA_W-1:0]           rdata
);

	localparam int OFF_W = $clog2(CAPACITY);
	localparam int RW    = OFF_W - 3;
	localparam int ROWS  = (CAPACITY + BYTES - 1) / BYTES;

	logic [RW-1:0]     base_row;
	logic [LANE_W-1:0] lo;
	logic [LANE_W-1:0] lo_q;
	logic [LANE_W-1:0] lm_q;
	logic [DATA_W-1:0] bank_rd;

	assign base_row = off[OFF_W-1:LANE_W];
	assign lo       = off[LANE_W-1:0];

	// hold the read alignment until the data is consumed
	always_ff @(posedge clk) begin
		if (rd_en) begin
			lo_q <= lo;
			lm_q <= len_m1;
		end
	end

	for (genvar b = 0; b < BYTES; b++) begin : g_bank
		logic [LANE_W-1:0] k;
		logic [LANE_W-1:0] sel;
		logic              used;
		logic              wrap;
		logic [RW-1:0]     row;
		logic              we;
		logic [RW-1:0]     addr;
		logic [BYTE_W-1:0] wd;
		logic [LANE_W-1:0] rk;
		logic [LANE_W-1:0] rb;

		// bank b holds access byte k; banks below the start sit in the next row
		assign k    = LANE_W'(b) - lo;
		assign used = (k <= len_m1);
		assign wrap = (LANE_W'(b) < lo);
		assign row  = base_row + RW'(wrap);
		assign sel  = len_m1 - k;
		assign we   = clr_en | (wr_en & used);
		assign addr = clr_en ? clr_row : row;
		assign wd   = clr_en ? '0 : wdata[{sel, 3'b000} +: BYTE_W];

		betrm_ram #(
			.WIDTH(BYTE_W),
			.DEPTH(ROWS)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.re   (rd_en),
			.addr (addr),
			.wdata(wd),
			.rdata(bank_rd[BYTE_W*b +: BYTE_W])
		);

		// result byte b is access byte (len-1-b), right-aligned
		assign rk = lm_q - LANE_W'(b);
		assign rb = lo_q + rk;
		assign rdata[BYTE_W*b +: BYTE_W] = (LANE_W'(b) <= lm_q) ?
			bank_rd[{rb, 3'b000} +: BYTE_W] : '0;
	end

endmodule

`default_nettype wire

>>> hdl/betrm_dp.sv
// ----------------------------------------------------------------------------
// betrm_dp
// Datapath: item and size registers, region decode, the two bank sets and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module betrm_dp import betrm_pkg::*; #(
	parameter int          CAP_ONE  = 65536,
	parameter int          CAP_TWO  = 65536,
	parameter logic [31:0] BASE_TWO = 32'h1000_0000,
	parameter int          CLR_W    = 13
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_SIZE_W-1:0] cfg_data,
	input  wire logic [ACTION_W-1:0]   action,
	input  wire logic [ADDR_W-1:0]     address,
	input  wire logic [SIZE_W-1:0]     access_size,
	input  wire logic [DATA_W-1:0]     write_data,
	input  wire betrm_cmd_t            cmd,
	input  wire logic [CLR_W-1:0]      clr_row,
	output betrm_stat_t                status,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       ok,
	output logic [DATA_W-1:0]          read_data
);

	localparam int OFF1_W = $clog2(CAP_ONE);
	localparam int OFF2_W = $clog2(CAP_TWO);
	localparam int RW1    = OFF1_W - 3;
	localparam int RW2    = OFF2_W - 3;
	localparam int ROWS1  = (CAP_ONE + BYTES - 1) / BYTES;
	localparam int ROWS2  = (CAP_TWO + BYTES - 1) / BYTES;
	localparam logic [ADDR_W-1:0] CAP1_L = ADDR_W'(CAP_ONE);
	localparam logic [ADDR_W-1:0] CAP2_L = ADDR_W'(CAP_TWO);

	logic [CFG_SIZE_W-1:0] size_one_q;
	logic [CFG_SIZE_W-1:0] size_two_q;
	logic [ACTION_W-1:0]   action_q;
	logic [ADDR_W-1:0]     address_q;
	logic [SIZE_W-1:0]     size_q;
	logic [DATA_W-1:0]     wdata_q;
	logic                  res_ok_q;
	logic                  res_rd_q;
	logic                  res_two_q;
	logic                  out_valid_q;
	logic                  ok_q;
	logic [DATA_W-1:0]     read_data_q;

	logic [ADDR_W-1:0] phys;
	logic [ADDR_W-1:0] s1;
	logic [ADDR_W-1:0] s2;
	logic [ADDR_W-1:0] off2_full;
	logic [LEN_W-1:0]  len;
	logic              in_one;
	logic              fit_one;
	logic              in_two;
	logic              fit_two;
	logic              is_rw;
	logic              is_rd;
	logic              hit_one;
	logic              hit_two;
	logic              r1_clr;
	logic              r2_clr;
	logic [DATA_W-1:0] rd_one;
	logic [DATA_W-1:0] rd_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_one_q <= CFG_SIZE_RESET;
			size_two_q <= CFG_SIZE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_REGION_ONE_SIZE) begin
				size_one_q <= cfg_data;
			end else begin
				size_two_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q  <= action;
			address_q <= address;
			size_q    <= access_size;
			wdata_q   <= write_data;
		end
	end

	// decode
	assign phys = address_q[MIRROR_BIT] ? (address_q & PHYS_MASK) : address_q;
	assign s1   = (ADDR_W'(size_one_q) > CAP1_L) ? CAP1_L : ADDR_W'(size_one_q);
	assign s2   = (ADDR_W'(size_two_q) > CAP2_L) ? CAP2_L : ADDR_W'(size_two_q);
	assign len  = LEN_W'(1) << size_q;
	assign off2_full = phys - BASE_TWO;

	assign in_one  = (phys < s1);
	assign fit_one = ({1'b0, phys} + (ADDR_W+1)'(len)) <= {1'b0, s1};
	assign in_two  = !in_one && (phys >= BASE_TWO);
	assign fit_two = ({1'b0, off2_full} + (ADDR_W+1)'(len)) <= {1'b0, s2};

	assign is_rw   = (action_q == ACT_READ) || (action_q == ACT_WRITE);
	assign is_rd   = (action_q == ACT_READ);
	assign hit_one = is_rw && in_one && fit_one;
	assign hit_two = is_rw && in_two && fit_two;

	assign r1_clr = cmd.clr_en && (32'(clr_row) < 32'(ROWS1));
	assign r2_clr = cmd.clr_en && (32'(clr_row) < 32'(ROWS2));

	betrm_region #(
		.CAPACITY(CAP_ONE)
	) u_region_one (
		.clk    (clk),
		.off    (phys[OFF1_W-1:0]),
		.len_m1 (LANE_W'(len - LEN_W'(1))),
		.wr_en  (cmd.exec && hit_one && !is_rd),
		.rd_en  (cmd.exec && hit_one && is_rd),
		.wdata  (wdata_q),
		.clr_en (r1_clr),
		.clr_row(clr_row[RW1-1:0]),
		.rdata  (rd_one)
	);

	betrm_region #(
		.CAPACITY(CAP_TWO)
	) u_region_two (
		.clk    (clk),
		.off    (off2_full[OFF2_W-1:0]),
		.len_m1 (LANE_W'(len - LEN_W'(1))),
		.wr_en  (cmd.exec && hit_two && !is_rd),
		.rd_en  (cmd.exec && hit_two && is_rd),
		.wdata  (wdata_q),
		.clr_en (r2_clr),
		.clr_row(clr_row[RW2-1:0]),
		.rdata  (rd_two)
	);

	// outcome of the access, held while the banks return data
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_ok_q  <= (action_q == ACT_CLEAR) || hit_one || hit_two;
			res_rd_q  <= is_rd && (hit_one || hit_two);
			res_two_q <= hit_two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			ok_q        <= res_ok_q;
			read_data_q <= !res_rd_q ? '0 : (res_two_q ? rd_two : rd_one);
		end
	end

	assign status.is_clear = (action_q == ACT_CLEAR);
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign read_data = read_data_q;

endmodule

`default_nettype wire

>>> hdl/betrm_ctrl.sv
// ----------------------------------------------------------------------------
// betrm_ctrl
// Controller: sequences item accept, bank access, result hand-off and the
// row-by-row clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

`include "big_endian_two_region_memory_core_macros.svh"

module betrm_ctrl import betrm_pkg::*; #(
	parameter int CLR_ROWS = 8192
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire betrm_stat_t                 status,
	output betrm_cmd_t                       cmd,
	output logic [$clog2(CLR_ROWS)-1:0]      clr_row
);

	localparam int CLR_W = $clog2(CLR_ROWS);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [CLR_W-1:0] row_q;
	logic             report_q;
	logic             last_row;

	assign last_row = (row_q == CLR_W'(CLR_ROWS - 1));

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.exec   = 1'b0;
		cmd.clr_en = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (last_row) begin
					state_d = report_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = status.is_clear ? ST_CLEAR : ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					in_ready   = 1'b1;
					state_d    = in_valid ? ST_EXEC : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		cmd.load = in_valid && in_ready;
	end

	assign clr_row  = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			row_q    <= '0;
			report_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				row_q <= row_q + CLR_W'(1);
				if (last_row) begin
					report_q <= 1'b0;
				end
			end else if (state_q == ST_EXEC && status.is_clear) begin
				row_q    <= '0;
				report_q <= 1'b1;
			end
		end
	end

	`BETRM_ASSERT_NEXT(a_accept_to_exec, in_valid && in_ready, state_q == ST_EXEC, "accept did not start access")
	`BETRM_ASSERT_IMPL(a_finish_free, cmd.finish, status.out_free, "result loaded over a pending result")
	`BETRM_ASSERT_ALWAYS(a_exec_vs_clear, !(cmd.exec && cmd.clr_en), "access during clear sweep")
	`BETRM_ASSERT_NEXT(a_exec_to_done, state_q == ST_EXEC && !status.is_clear, state_q == ST_DONE, "access did not complete")

endmodule

`default_nettype wire

>>> hdl/big_endian_two_region_memory_core.sv
// ----------------------------------------------------------------------------
// big_endian_two_region_memory_core
// Two big-endian byte stores with region decode, sized access and clear.
// ----------------------------------------------------------------------------
// Each store is eight byte-wide banks, so any 1-, 2-, 4- or 8-byte access,
// aligned or not, touches every bank at most once. A read or write item is
// first decoded and used to access the banks, then its result is handed to
// the output register; with an idle output side the next item is accepted
// in that hand-off step, so an item is taken only once the last one is
// through its bank access. A clear sweeps one row of eight bytes per cycle
// across both stores at once. The same sweep runs after reset, during which
// no item is accepted; configuration writes are taken at any time. Results
// are held in an output register, so a new item is accepted while the
// previous result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module big_endian_two_region_memory_core import betrm_pkg::*; #(
	parameter int          REGION_ONE_CAPACITY = 65536,
	parameter int          REGION_TWO_CAPACITY = 65536,
	parameter logic [31:0] REGION_TWO_BASE     = 32'h1000_0000
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_SIZE_W-1:0] cfg_data,

	// item channel
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [ACTION_W-1:0]   action,
	input  wire logic [ADDR_W-1:0]     address,
	input  wire logic [SIZE_W-1:0]     access_size,
	input  wire logic [DATA_W-1:0]     write_data,

	// result channel
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       ok,
	output logic [DATA_W-1:0]          read_data
);

	// rows per store; the clearing sweep covers the larger one
	localparam int ROWS_ONE = (REGION_ONE_CAPACITY + BYTES - 1) / BYTES;
	localparam int ROWS_TWO = (REGION_TWO_CAPACITY + BYTES - 1) / BYTES;
	localparam int CLR_ROWS = (ROWS_ONE > ROWS_TWO) ? ROWS_ONE : ROWS_TWO;
	localparam int CLR_W    = $clog2(CLR_ROWS);

	betrm_cmd_t       cmd;
	betrm_stat_t      status;
	logic [CLR_W-1:0] clr_row;

	// size registers take a write in any cycle
	assign cfg_ready = 1'b1;

	betrm_ctrl #(
		.CLR_ROWS(CLR_ROWS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd),
		.clr_row (clr_row)
	);

	betrm_dp #(
		.CAP_ONE (REGION_ONE_CAPACITY),
		.CAP_TWO (REGION_TWO_CAPACITY),
		.BASE_TWO(REGION_TWO_BASE),
		.CLR_W   (CLR_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.action     (action),
		.address    (address),
		.access_size(access_size),
		.write_data (write_data),
		.cmd        (cmd),
		.clr_row    (clr_row),
		.status     (status),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.read_data  (read_data)
	);

endmodule

`default_nettype wire
